// ===== sv/asg_pkg.sv =====
// Shared types and constants for the antenna scan angle generator.
// No dependencies.
package asg_pkg;

   // divider chain sizes
   localparam int QUO_BITS = 45;   // quotient bits produced by the cell chain
   localparam int DVD_W    = 61;   // swept distance width
   localparam int DIV_W    = 62;   // divisor width

   localparam logic signed [25:0] DEG360     = 26'sd23592960;
   localparam logic [61:0]        CIRC_MOD   = 62'd1546188226560; // 360 deg in 2^-32 units

   typedef enum logic [2:0] {
      MODE_FIXED = 3'd0,
      MODE_CIRC  = 3'd1,
      MODE_SECT2 = 3'd2,
      MODE_SECT1 = 3'd3,
      MODE_RAST2 = 3'd4,
      MODE_RAST1 = 3'd5
   } mode_type;

   typedef enum logic [2:0] {
      CSR_MODE  = 3'd0,
      CSR_RATE  = 3'd1,
      CSR_START = 3'd2,
      CSR_END   = 3'd3,
      CSR_FLY   = 3'd4,
      CSR_BARS  = 3'd5,
      CSR_BARW  = 3'd6,
      CSR_BASE  = 3'd7
   } csr_index_type;

   // word moving down the divider chain
   typedef struct packed {
      logic              valid;
      logic [DVD_W-1:0]  rem;
      logic [7:0]        qm;    // quotient so far, modulo the bar count
   } div_type;

endpackage

// ===== sv/asg_req_if.sv =====
// Request channel: one time stamp word per handshake.
// No dependencies.
interface asg_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] time_now;

   modport source (output valid, output time_now, input ready);
   modport sink   (input valid, input time_now, output ready);
endinterface

// ===== sv/asg_rsp_if.sv =====
// Response channel: one azimuth/elevation word per handshake.
// No dependencies.
interface asg_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [25:0] beam_azimuth;
   logic signed [25:0] beam_elevation;

   modport source (output valid, output beam_azimuth, output beam_elevation, input ready);
   modport sink   (input valid, input beam_azimuth, input beam_elevation, output ready);
endinterface

// ===== sv/asg_div_cell.sv =====
// One restoring-division cell: decides one quotient bit and keeps the
// running quotient modulo the bar count. Uses asg_pkg.
module asg_div_cell #(
   parameter int SHIFT = 0
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            enable,
   input  asg_pkg::div_type                cell_in,
   input  logic [asg_pkg::DIV_W-1:0]       divisor,
   input  logic [7:0]                      bars,
   output asg_pkg::div_type                cell_out
);
   logic [asg_pkg::DVD_W-1:0] hi;
   logic                      take;
   logic [8:0]                q9;
   asg_pkg::div_type          cell_ff, cell_in_nx;

   // compare/subtract at this bit position
   always_comb begin
      hi   = cell_in.rem >> SHIFT;
      take = {1'b0, hi} >= divisor;
      q9   = {cell_in.qm, take};
      if (q9 >= {1'b0, bars}) begin
         q9 = q9 - {1'b0, bars};
      end
      cell_in_nx.valid = cell_in.valid;
      cell_in_nx.rem   = take ? cell_in.rem - (divisor[asg_pkg::DVD_W-1:0] << SHIFT)
                              : cell_in.rem;
      cell_in_nx.qm    = q9[7:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else if (enable) begin
         cell_ff.valid <= cell_in_nx.valid;
      end
      if (enable) begin
         cell_ff.rem <= cell_in_nx.rem;
         cell_ff.qm  <= cell_in_nx.qm;
      end
   end

   assign cell_out = cell_ff;
endmodule

// ===== sv/antenna_scan_angle_generator.sv =====
// Antenna scan angle generator top level: config registers, distance
// multiply, divider cell chain and angle output stages. Uses asg_pkg,
// asg_req_if, asg_rsp_if and asg_div_cell.
// Pipeline: 3 front stages, 45 divider cells and 2 output stages between the accepted
// time word and the result word. Throughput: one word per cycle; the
// 45-cell divider chain is fully pipelined. Any stall on rsp stalls the whole pipe.
// Reset: synchronous, clears all valid bits and loads register defaults.
module antenna_scan_angle_generator (
   input  logic           clock,
   input  logic           reset,
   asg_req_if.sink        req,
   asg_rsp_if.source      rsp,
   input  logic           csr_we,
   input  logic [2:0]     csr_index,
   input  logic [31:0]    csr_wdata
);
   localparam int NC = asg_pkg::QUO_BITS;

   // configuration registers
   logic [2:0]         mode_ff;
   logic signed [26:0] rate_ff;
   logic signed [25:0] start_ff, end_ff, bw_ff, base_ff;
   logic [31:0]        fly_ff;
   logic [7:0]         barc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= 3'd0;
         rate_ff  <= 27'sd983040;
         start_ff <= 26'sd0;
         end_ff   <= 26'sd0;
         fly_ff   <= 32'd0;
         barc_ff  <= 8'd0;
         bw_ff    <= 26'sd327680;
         base_ff  <= 26'sd0;
      end else if (csr_we) begin
         unique case (asg_pkg::csr_index_type'(csr_index))
            asg_pkg::CSR_MODE:  mode_ff  <= csr_wdata[2:0];
            asg_pkg::CSR_RATE:  rate_ff  <= csr_wdata[26:0];
            asg_pkg::CSR_START: start_ff <= csr_wdata[25:0];
            asg_pkg::CSR_END:   end_ff   <= csr_wdata[25:0];
            asg_pkg::CSR_FLY:   fly_ff   <= csr_wdata;
            asg_pkg::CSR_BARS:  barc_ff  <= csr_wdata[7:0];
            asg_pkg::CSR_BARW:  bw_ff    <= csr_wdata[25:0];
            asg_pkg::CSR_BASE:  base_ff  <= csr_wdata[25:0];
            default: ;
         endcase
      end
   end

   // mode decode
   logic is_circ, is_two, is_rast, is_scan;
   always_comb begin
      is_circ = mode_ff == asg_pkg::MODE_CIRC;
      is_two  = mode_ff == asg_pkg::MODE_SECT2 || mode_ff == asg_pkg::MODE_RAST2;
      is_rast = mode_ff == asg_pkg::MODE_RAST2 || mode_ff == asg_pkg::MODE_RAST1;
      is_scan = mode_ff == asg_pkg::MODE_SECT2 || mode_ff == asg_pkg::MODE_SECT1 || is_rast;
   end

   // derived config terms, registered behind the config registers; they settle after a write
   logic [26:0]               mag;
   logic [28:0]               r_in, r_ff;
   logic signed [26:0]        diff;
   logic [25:0]               span_in, span_ff;
   logic                      up_ff;
   logic [60:0]               fb_ff;
   logic [41:0]               len;
   logic [asg_pkg::DIV_W-1:0] div_in, div_ff;
   logic [7:0]                bars_in, bars_ff;

   always_comb begin
      mag     = rate_ff[26] ? 27'(-rate_ff) : 27'(rate_ff);
      r_in    = ({2'b0, mag} << 2) + ({2'b0, mag} << 1);
      diff    = 27'(end_ff) - 27'(start_ff);
      span_in = diff[26] ? 26'(-diff) : diff[25:0];
      len     = {span_ff, 16'd0};
      if (is_circ) begin
         div_in = asg_pkg::CIRC_MOD;
      end else if (is_two) begin
         div_in = 62'(len);
      end else begin
         div_in = 62'(len) + 62'(fb_ff);
      end
      if (mode_ff == asg_pkg::MODE_SECT2) begin
         bars_in = 8'd2;
      end else if (is_rast) begin
         bars_in = (barc_ff == 8'd0) ? 8'd1 : barc_ff;
      end else begin
         bars_in = 8'd1;
      end
   end

   always_ff @(posedge clock) begin
      r_ff    <= r_in;
      span_ff <= span_in;
      up_ff   <= !diff[26];
      fb_ff   <= r_ff * fly_ff;
      div_ff  <= div_in;
      bars_ff <= bars_in;
   end

   // front stages: time capture, distance multiply, chain entry
   logic                    en;
   logic                    v1_ff, v2_ff;
   logic [31:0]             t1_ff;
   logic [60:0]             d2_ff;
   asg_pkg::div_type        c0_ff;
   asg_pkg::div_type        chain [0:NC];
   logic                    rv_ff;

   assign en        = !rv_ff || rsp.ready;
   assign req.ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff       <= 1'b0;
         v2_ff       <= 1'b0;
         c0_ff.valid <= 1'b0;
      end else if (en) begin
         v1_ff       <= req.valid;
         v2_ff       <= v1_ff;
         c0_ff.valid <= v2_ff;
      end
      if (en) begin
         t1_ff    <= req.time_now;
         d2_ff    <= r_ff * t1_ff;
         c0_ff.rem <= d2_ff;
         c0_ff.qm  <= 8'd0;
      end
   end

   assign chain[0] = c0_ff;

   // divider cell chain, one quotient bit per cell, MSB first
   for (genvar g = 0; g < NC; g++) begin : g_cell
      asg_div_cell #(.SHIFT(NC - 1 - g)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .enable   (en),
         .cell_in  (chain[g]),
         .divisor  (div_ff),
         .bars     (bars_ff),
         .cell_out (chain[g+1])
      );
   end

   // output stage 1: azimuth select, bar elevation product
   asg_pkg::div_type   tail;
   logic               active;
   logic [60:0]        y;
   logic signed [26:0] tr, s27, e27, az27;
   logic signed [34:0] prod_in, prod_ff;
   logic [25:0]        az1_ff;
   logic               v3_ff;

   always_comb begin
      tail   = chain[NC];
      active = is_scan && span_ff != 26'd0 && r_ff != 29'd0;
      y      = (rate_ff[26] && tail.rem != 61'd0)
               ? asg_pkg::CIRC_MOD[60:0] - tail.rem : tail.rem;
      tr     = {1'b0, tail.rem[41:16]};
      s27    = 27'(start_ff);
      e27    = 27'(end_ff);
      az27   = s27;
      if (is_circ) begin
         az27 = {2'b0, y[40:16]};
      end else if (active) begin
         if (is_two) begin
            if (tail.qm[0]) begin
               az27 = up_ff ? e27 - tr : e27 + tr;
            end else begin
               az27 = up_ff ? s27 + tr : s27 - tr;
            end
         end else if (tail.rem <= 61'(len)) begin
            az27 = up_ff ? s27 + tr : s27 - tr;
         end
      end
      prod_in = $signed({1'b0, tail.qm}) * bw_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en) begin
         v3_ff <= tail.valid;
      end
      if (en) begin
         az1_ff  <= az27[25:0];
         prod_ff <= active && is_rast ? prod_in : 35'sd0;
      end
   end

   // output stage 2: elevation sum and saturation
   logic signed [35:0] el_sum;
   logic signed [25:0] el_in, az_ff, el_ff;

   always_comb begin
      el_sum = 36'(base_ff) + 36'(prod_ff);
      if (el_sum > 36'(asg_pkg::DEG360)) begin
         el_in = asg_pkg::DEG360;
      end else if (el_sum < -36'(asg_pkg::DEG360)) begin
         el_in = -asg_pkg::DEG360;
      end else begin
         el_in = el_sum[25:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff <= 1'b0;
      end else if (en) begin
         rv_ff <= v3_ff;
      end
      if (en) begin
         az_ff <= az1_ff;
         el_ff <= el_in;
      end
   end

   assign rsp.valid          = rv_ff;
   assign rsp.beam_azimuth   = az_ff;
   assign rsp.beam_elevation = el_ff;

   // checks
   a_el_range: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.beam_elevation <= asg_pkg::DEG360 &&
                     rsp.beam_elevation >= -asg_pkg::DEG360))
      else $error("elevation outside saturation range");

   a_qm_range: assert property (@(posedge clock) disable iff (reset)
      (tail.valid && bars_ff != 8'd0) |-> tail.qm < bars_ff)
      else $error("bar index not reduced below bar count");

   a_circ_range: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && mode_ff == asg_pkg::MODE_CIRC) |->
         (!rsp.beam_azimuth[25] && rsp.beam_azimuth < asg_pkg::DEG360))
      else $error("circular azimuth outside [0,360)");

endmodule
